// ===== rtl/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// rps_pkg: shared definitions for the random permutation shuffler
// Field widths, reset values, request payload types and the size clamp.
// ----------------------------------------------------------------------------
package rps_pkg;

  localparam int WORD_W  = 16;  // random word
  localparam int VALUE_W = 7;   // element value
  localparam int POS_W   = 6;   // element position
  localparam int SIZE_W  = 7;   // perm_size register
  localparam int DIGIT_W = 4;   // remainder bits retired per divider cycle

  localparam int MAX_SIZE_DEFAULT = 64;

  // Largest size the perm_size register can name.
  localparam int SIZE_CAP = 2 ** SIZE_W - 1;

  localparam logic [SIZE_W-1:0] PERM_SIZE_RESET = 7'd64;

  typedef struct packed {
    logic [WORD_W-1:0] random_word;
  } rand_t;

  typedef struct packed {
    logic [VALUE_W-1:0] element_value;
    logic [POS_W-1:0]   element_position;
    logic               last_element;
  } elem_t;

  // Clamp the programmed size into 1..cap.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size,
                                                 input logic [SIZE_W-1:0] cap);
    logic [SIZE_W-1:0] n;
    n = size;
    if (n == '0) begin
      n = SIZE_W'(1);
    end
    if (n > cap) begin
      n = cap;
    end
    return n;
  endfunction

endpackage

// ===== rtl/rps_stream_if.sv =====
// ----------------------------------------------------------------------------
// rps_stream_if: valid/ready request channel
// Carries one payload of any packed type per accepted request.
// ----------------------------------------------------------------------------
interface rps_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/rps_front.sv =====
// ----------------------------------------------------------------------------
// rps_front: request intake and swap index selection
// Tracks the shuffle position and reduces the random word modulo the
// remaining range, four bits per cycle, then queues the step.
// ----------------------------------------------------------------------------
module rps_front #(
  parameter int  DEPTH  = rps_pkg::MAX_SIZE_DEFAULT,
  parameter type step_t = logic
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rps_pkg::SIZE_W-1:0] n_eff,
  rps_stream_if.sink                word_req,
  output logic                      push_valid,
  input  logic                      push_ready,
  output step_t                     push_data
);

  localparam int IW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int WW    = rps_pkg::WORD_W;
  localparam int DW    = rps_pkg::DIGIT_W;
  localparam int STEPS = WW / DW;
  localparam int CW    = $clog2(STEPS);
  localparam logic [CW-1:0] LAST_STEP = CW'(STEPS - 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t        state;
  logic [IW-1:0]  step_pos;
  logic [IW-1:0]  pos;
  logic           last;
  logic [NW-1:0]  range;
  logic [NW-1:0]  rem;
  logic [WW-1:0]  dividend;
  logic [CW-1:0]  cnt;

  logic [NW-1:0]  n;
  logic           restart;
  logic [IW-1:0]  pos_start;
  logic           last_start;

  // One restoring remainder step per bit of the digit.
  function automatic logic [NW-1:0] rem_digit(input logic [NW-1:0] r_in,
                                              input logic [DW-1:0] digit,
                                              input logic [NW-1:0] div);
    logic [NW:0]   t;
    logic [NW-1:0] r;
    r = r_in;
    for (int i = DW - 1; i >= 0; i--) begin
      t = {r, digit[i]};
      if (t >= {1'b0, div}) begin
        t = t - {1'b0, div};
      end
      r = t[NW-1:0];
    end
    return r;
  endfunction

  assign n          = NW'(n_eff);
  assign restart    = NW'(step_pos) >= n;
  assign pos_start  = restart ? '0 : step_pos;
  assign last_start = NW'(pos_start) == (n - NW'(1));

  assign word_req.ready     = (state == F_IDLE);
  assign push_valid         = (state == F_PUSH);
  assign push_data.pos      = pos;
  assign push_data.swap_idx = IW'(NW'(pos) + rem);
  assign push_data.last     = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      step_pos <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (word_req.valid) begin
            step_pos <= last_start ? '0 : pos_start + IW'(1);
            state    <= F_DIV;
          end
        end
        F_DIV: begin
          if (cnt == LAST_STEP) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && word_req.valid) begin
      pos      <= pos_start;
      last     <= last_start;
      range    <= n - NW'(pos_start);
      rem      <= '0;
      dividend <= word_req.payload.random_word;
      cnt      <= '0;
    end else if (state == F_DIV) begin
      rem      <= rem_digit(rem, dividend[WW-1 -: DW], range);
      dividend <= dividend << DW;
      cnt      <= cnt + CW'(1);
    end
  end

endmodule

// ===== rtl/rps_queue.sv =====
// ----------------------------------------------------------------------------
// rps_queue: two-entry step queue
// Decouples index selection from the table swap.
// ----------------------------------------------------------------------------
module rps_queue #(
  parameter type step_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  step_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output step_t pop_data
);

  step_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/rps_back.sv =====
// ----------------------------------------------------------------------------
// rps_back: table swap and result register
// Reads both entries, writes them back crossed over one port write per
// cycle, and holds the finished element until the sink takes it.
// ----------------------------------------------------------------------------
module rps_back #(
  parameter int  DEPTH  = rps_pkg::MAX_SIZE_DEFAULT,
  parameter type step_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  pop_valid,
  output logic  pop_ready,
  input  step_t pop_data,
  rps_stream_if.source elem_req
);

  localparam int IW = $clog2(DEPTH);
  localparam int VW = rps_pkg::VALUE_W;
  localparam int PW = rps_pkg::POS_W;

  typedef enum logic [2:0] {
    B_IDLE   = 3'b001,
    B_SWAP   = 3'b010,
    B_FINISH = 3'b100
  } bstate_t;

  bstate_t          state;
  logic [VW-1:0]    table_value [DEPTH];
  logic [DEPTH-1:0] written;
  step_t            cur;
  logic [VW-1:0]    rd_a;
  logic [VW-1:0]    rd_b;
  logic [VW-1:0]    b_val;
  logic             out_valid;
  rps_pkg::elem_t   out_data;

  logic [DEPTH-1:0] marks_live;
  logic [DEPTH-1:0] marks_swap;
  logic [VW-1:0]    a_now;
  logic [VW-1:0]    b_now;
  logic             out_free;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [VW-1:0]    wr_data;

  // Position zero opens a new permutation: every mark reads as clear.
  always_comb begin
    marks_live = (cur.pos == '0) ? '0 : written;
    marks_swap = marks_live;
    marks_swap[cur.swap_idx] = 1'b1;
    a_now = marks_live[cur.pos] ? rd_a : VW'(cur.pos) + VW'(1);
    b_now = marks_live[cur.swap_idx] ? rd_b : VW'(cur.swap_idx) + VW'(1);
  end

  assign out_free = !out_valid || elem_req.ready;
  assign wr_en    = (state == B_SWAP) || (state == B_FINISH);
  assign wr_addr  = (state == B_SWAP) ? cur.swap_idx : cur.pos;
  assign wr_data  = (state == B_SWAP) ? a_now : b_val;

  assign pop_ready        = (state == B_IDLE);
  assign elem_req.valid   = out_valid;
  assign elem_req.payload = out_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_value[wr_addr] <= wr_data;
    end
    if (state == B_IDLE) begin
      rd_a <= table_value[pop_data.pos];
      rd_b <= table_value[pop_data.swap_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      written   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == B_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (elem_req.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop_valid) begin
            state <= B_SWAP;
          end
        end
        B_SWAP: begin
          written <= marks_swap;
          state   <= B_FINISH;
        end
        B_FINISH: begin
          written[cur.pos] <= 1'b1;
          if (out_free) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && pop_valid) begin
      cur <= pop_data;
    end
    if (state == B_SWAP) begin
      b_val <= b_now;
    end
    if (state == B_FINISH && out_free) begin
      out_data.element_value    <= b_val;
      out_data.element_position <= PW'(cur.pos);
      out_data.last_element     <= cur.last;
    end
  end

endmodule

// ===== rtl/random_permutation_shuffler.sv =====
// ----------------------------------------------------------------------------
// random_permutation_shuffler: forward Fisher-Yates shuffle, one element per request
// The front end takes no new random word until the remainder unit has finished and its step is queued.
// Reset: size 64, position 0, all table marks cleared.
// ----------------------------------------------------------------------------
module random_permutation_shuffler #(
  parameter int MAX_SIZE = rps_pkg::MAX_SIZE_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  rps_stream_if.sink   cfg,
  rps_stream_if.sink   rand_req,
  rps_stream_if.source elem_req
);

  localparam int SW = rps_pkg::SIZE_W;
  localparam int PW = rps_pkg::POS_W;

  // Only sizes the register can name are ever reached, so the table need
  // not grow past that even for a larger capacity.
  localparam int DEPTH = (MAX_SIZE < rps_pkg::SIZE_CAP) ? MAX_SIZE : rps_pkg::SIZE_CAP;
  localparam int IW    = $clog2(DEPTH);
  localparam logic [SW-1:0] DEPTH_V = SW'(DEPTH);

  // One queued shuffle step: the position, the partner it swaps with, and
  // whether it closes the permutation.
  typedef struct packed {
    logic [IW-1:0] pos;
    logic [IW-1:0] swap_idx;
    logic          last;
  } step_t;

  logic [SW-1:0] perm_size;
  logic [SW-1:0] n_eff;

  logic  push_valid;
  logic  push_ready;
  step_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  step_t pop_data;

  // Configuration: always ready; the user must write it only while the block is idle (not enforced here).
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_size <= rps_pkg::PERM_SIZE_RESET;
    end else if (cfg.valid) begin
      perm_size <= cfg.payload;
    end
  end

  // Clamp the size into 1..DEPTH once, for the front end and the checks.
  assign n_eff = rps_pkg::eff_size(perm_size, DEPTH_V);

  // Front: take the random word, pick the swap partner by remainder.
  rps_front #(
    .DEPTH  (DEPTH),
    .step_t (step_t)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .n_eff      (n_eff),
    .word_req   (rand_req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Hold up to two selected steps while the swap catches up.
  rps_queue #(
    .step_t (step_t)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: swap the two table entries and present the finished element.
  rps_back #(
    .DEPTH  (DEPTH),
    .step_t (step_t)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .elem_req  (elem_req)
  );

`ifndef NO_ASSERTIONS
  // The remainder unit stays busy after taking a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    rand_req.valid && rand_req.ready |=> !rand_req.ready)
    else $error("random word accepted while remainder unit busy");

  // The closing element sits at the last position of the current size.
  a_last_position: assert property (@(posedge clk) disable iff (rst)
    elem_req.valid && elem_req.ready && elem_req.payload.last_element
    |-> elem_req.payload.element_position == PW'(n_eff - SW'(1)))
    else $error("last element at wrong position");

  // Every emitted value is a table value in 1..DEPTH.
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    elem_req.valid |-> elem_req.payload.element_value != '0
                       && elem_req.payload.element_value <= DEPTH_V)
    else $error("element value out of range");
`endif

endmodule

// ===== dv/random_permutation_shuffler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_permutation_shuffler_tb: self-checking bench for the shuffler
// Feeds random words, mirrors the forward Fisher-Yates table in the bench
// and compares every emitted element against the mirrored shuffle, across
// several permutation sizes, with random idling and back-pressure.
// ----------------------------------------------------------------------------
module random_permutation_shuffler_tb;

  import rps_pkg::*;

  localparam int TABLE_DEPTH   = MAX_SIZE_DEFAULT;
  localparam int SETTLE_CYCLES = 20;    // idle wait after a drain
  localparam int STALL_LIMIT   = 4000;  // cycles with no request moving
  localparam int LONG_HOLD     = 400;   // receiver hold-off to fill the block

  logic clk;
  logic rst;

  rps_stream_if #(.payload_t(logic [SIZE_W-1:0])) cfg_if ();
  rps_stream_if #(.payload_t(rand_t))             rand_if ();
  rps_stream_if #(.payload_t(elem_t))             elem_if ();

  random_permutation_shuffler #(
    .MAX_SIZE(TABLE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_if),
    .rand_req (rand_if),
    .elem_req (elem_if)
  );

  // Mirrored shuffle state: programmed size, table contents, written marks
  // and the position of the next step.
  logic [SIZE_W-1:0]  perm_size_reg;
  logic [VALUE_W-1:0] slot_value [TABLE_DEPTH];
  bit                 slot_written [TABLE_DEPTH];
  int unsigned        step_pos;

  logic [WORD_W-1:0] pending_words [$];
  elem_t             expected_elems [$];

  bit rand_offering;   // a word is on the request channel, not yet taken
  int src_gap;
  bit src_idle_en;
  bit sink_idle_en;
  bit quiet_mode;      // no idling at all in the closing phase
  bit long_hold_req;
  int hold_cnt;
  int stall_cnt;
  int err_count;
  int idle_cycles;

  // --------------------------------------------------------------------------
  // Shuffle predictor
  // --------------------------------------------------------------------------
  function automatic logic [VALUE_W-1:0] slot_read(input int unsigned idx);
    return slot_written[idx] ? slot_value[idx] : VALUE_W'(idx + 1);
  endfunction

  function automatic void slot_store(input int unsigned idx, input logic [VALUE_W-1:0] v);
    slot_value[idx]   = v;
    slot_written[idx] = 1'b1;
  endfunction

  function automatic void restart_perm();
    foreach (slot_written[k]) slot_written[k] = 1'b0;
    step_pos = 0;
  endfunction

  // One shuffle step: pick r in [pos, n), swap entries pos and r, emit pos.
  function automatic elem_t shuffle_step(input logic [WORD_W-1:0] word);
    int unsigned        n;
    int unsigned        span;
    int unsigned        pick;
    logic [VALUE_W-1:0] at_pos;
    logic [VALUE_W-1:0] at_pick;
    elem_t              e;
    n = perm_size_reg;
    if (n == 0) n = 1;                      // size zero acts as one
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;   // clamp to capacity
    // A size shrunk below the current position restarts the permutation.
    if (step_pos >= n) restart_perm();
    span    = n - step_pos;
    pick    = step_pos + (int'(word) % span);
    at_pos  = slot_read(step_pos);
    at_pick = slot_read(pick);
    slot_store(pick, at_pos);
    slot_store(step_pos, at_pick);
    e.element_value    = at_pick;
    e.element_position = POS_W'(step_pos);
    e.last_element     = (step_pos == n - 1);
    if (e.last_element) begin
      restart_perm();
    end else begin
      step_pos = step_pos + 1;
    end
    return e;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and known input levels from time zero
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst             = 1'b1;
    cfg_if.valid    = 1'b0;
    cfg_if.payload  = '0;
    rand_if.valid   = 1'b0;
    rand_if.payload = '0;
    elem_if.ready   = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Word driver: advance on the falling edge, pull from the pending queue.
  // Keep valid high across back-to-back requests; insert idle bursts between.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      rand_if.valid <= 1'b0;
    end else if (!rand_offering) begin
      if (src_gap > 0) begin
        src_gap = src_gap - 1;
        rand_if.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        rand_if.payload <= rand_t'(pending_words.pop_front());
        rand_if.valid   <= 1'b1;
        rand_offering = 1'b1;
        if (!quiet_mode && src_idle_en && $urandom_range(0, 3) == 0) begin
          src_gap = $urandom_range(1, 9);
        end
      end else begin
        rand_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Element receiver: random stall bursts, plus one long hold-off on request
  // from the sequence, counted down here.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_cnt      = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (rst) begin
      elem_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      elem_if.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt = stall_cnt - 1;
      elem_if.ready <= 1'b0;
    end else begin
      elem_if.ready <= 1'b1;
      if (!quiet_mode && sink_idle_en && $urandom_range(0, 4) == 0) begin
        stall_cnt = $urandom_range(1, 9);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample on the rising edge. Predict on each accepted word,
  // check each accepted element against the oldest prediction, and kill
  // the run if nothing moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    elem_t want;
    elem_t got;
    bit    moved;
    moved = 1'b0;
    if (!rst) begin
      if (rand_if.valid && rand_if.ready) begin
        expected_elems.push_back(shuffle_step(rand_if.payload.random_word));
        rand_offering = 1'b0;
        moved = 1'b1;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        moved = 1'b1;
      end
      if (elem_if.valid && elem_if.ready) begin
        moved = 1'b1;
        got   = elem_if.payload;
        if (expected_elems.size() == 0) begin
          $error("unexpected element: value %0d position %0d last %0d",
                 got.element_value, got.element_position, got.last_element);
          err_count = err_count + 1;
        end else begin
          want = expected_elems.pop_front();
          if (got.element_value !== want.element_value) begin
            $error("element_value: expected %0d, got %0d",
                   want.element_value, got.element_value);
            err_count = err_count + 1;
          end
          if (got.element_position !== want.element_position) begin
            $error("element_position: expected %0d, got %0d",
                   want.element_position, got.element_position);
            err_count = err_count + 1;
          end
          if (got.last_element !== want.last_element) begin
            $error("last_element: expected %0d, got %0d",
                   want.last_element, got.last_element);
            err_count = err_count + 1;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence helpers
  // --------------------------------------------------------------------------

  // Hold until every pending word is taken and every element has come back.
  task automatic drain_all();
    do @(posedge clk);
    while (pending_words.size() != 0 || rand_offering || expected_elems.size() != 0);
  endtask

  // Program perm_size; only called with the block idle.
  task automatic write_perm_size(input logic [SIZE_W-1:0] size);
    @(negedge clk);
    cfg_if.payload <= size;
    cfg_if.valid   <= 1'b1;
    do @(posedge clk);
    while (!(cfg_if.valid && cfg_if.ready));
    perm_size_reg = size;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Drain, let the block settle, then change the size.
  task automatic next_phase(input logic [SIZE_W-1:0] size);
    drain_all();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_perm_size(size);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return WORD_W'($urandom_range(0, 63));
      default: return WORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return SIZE_W'(0);
      1:       return SIZE_W'(1);
      2:       return SIZE_W'(2);
      3:       return SIZE_W'(64);
      4:       return SIZE_W'(127);
      5:       return SIZE_W'($urandom_range(65, 126));
      default: return SIZE_W'($urandom_range(3, 63));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int n_items;
    rand_offering = 1'b0;
    src_gap       = 0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    quiet_mode    = 1'b0;
    long_hold_req = 1'b0;
    hold_cnt      = 0;
    stall_cnt     = 0;
    err_count     = 0;
    idle_cycles   = 0;
    perm_size_reg = PERM_SIZE_RESET;
    restart_perm();

    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset size 64, word extremes and alternating bit patterns,
    // leaving the permutation part way through.
    pending_words.push_back(16'h0000);
    pending_words.push_back(16'hFFFF);
    pending_words.push_back(16'h5555);
    pending_words.push_back(16'hAAAA);
    pending_words.push_back(16'h0001);
    pending_words.push_back(16'h8000);
    pending_words.push_back(16'h003F);
    pending_words.push_back(16'h7FFF);

    // Shrink the size below the current position: restart mid-permutation,
    // then run two whole permutations of three.
    next_phase(SIZE_W'(3));
    pending_words.push_back(16'hFFFF);
    pending_words.push_back(16'h0000);
    pending_words.push_back(16'h0001);
    pending_words.push_back(16'h0002);
    pending_words.push_back(16'hFFFE);
    pending_words.push_back(16'h7FFF);

    // Size zero behaves as a single element.
    next_phase(SIZE_W'(0));
    pending_words.push_back(16'h0000);
    pending_words.push_back(16'hFFFF);

    // Single element.
    next_phase(SIZE_W'(1));
    pending_words.push_back(16'h1234);
    pending_words.push_back(16'hFFFF);

    // Size above capacity saturates.
    next_phase(SIZE_W'(127));
    pending_words.push_back(16'hFFFF);
    pending_words.push_back(16'h0040);
    pending_words.push_back(16'h0000);

    // Smallest real shuffle.
    next_phase(SIZE_W'(2));
    pending_words.push_back(16'h0000);
    pending_words.push_back(16'h0001);
    pending_words.push_back(16'hFFFF);
    pending_words.push_back(16'hFFFE);

    // Random phases, each at its own size and idling mix.
    for (int ph = 0; ph < 10; ph++) begin
      next_phase(pick_size());
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      n_items      = $urandom_range(120, 220);
      // Hold the receiver off long enough to back the block up into its input.
      if (ph == 1) long_hold_req = 1'b1;
      for (int k = 0; k < n_items; k++) begin
        pending_words.push_back(pick_word());
        // Pause the sender half way until every element is back.
        if (ph == 3 && k == n_items / 2) drain_all();
      end
    end

    // Closing phase at full size with no idling on either side.
    next_phase(SIZE_W'(64));
    quiet_mode = 1'b1;
    for (int k = 0; k < 200; k++) begin
      pending_words.push_back(pick_word());
    end

    drain_all();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_elems.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
